FILE: hdl/mtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtp_pkg: shared types and constants for the MAC address text parser
// Character codes, layout lengths, hex decode and the result record.
// ----------------------------------------------------------------------------
package mtp_pkg;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] Char0     = 8'h30;
  localparam logic [7:0] Char9     = 8'h39;
  localparam logic [7:0] CharLa    = 8'h61;
  localparam logic [7:0] CharLf    = 8'h66;
  localparam logic [7:0] CharUa    = 8'h41;
  localparam logic [7:0] CharUf    = 8'h46;

  localparam int unsigned PosW     = 5;
  localparam int unsigned AddrW    = 48;
  localparam logic [PosW-1:0] SixLen   = 5'd17;
  localparam logic [PosW-1:0] ThreeLen = 5'd14;
  localparam logic [PosW-1:0] PosMax   = 5'd31;

  // Layout codes
  localparam logic LayoutSix   = 1'b0;
  localparam logic LayoutThree = 1'b1;

  typedef struct packed {
    logic             parse_ok;
    logic             layout;
    logic [AddrW-1:0] mac_address;
  } result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  // Decode one character as a hex digit of either case
  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t       h;
    logic [7:0] diff;
    h    = '0;
    diff = '0;
    if (c >= Char0 && c <= Char9) begin
      diff     = c - Char0;
      h.is_hex = 1'b1;
      h.value  = diff[3:0];
    end else if (c >= CharLa && c <= CharLf) begin
      diff     = c - CharLa + 8'd10;
      h.is_hex = 1'b1;
      h.value  = diff[3:0];
    end else if (c >= CharUa && c <= CharUf) begin
      diff     = c - CharUa + 8'd10;
      h.is_hex = 1'b1;
      h.value  = diff[3:0];
    end
    return h;
  endfunction

  // Colon slots of the XX:XX:XX:XX:XX:XX layout (past the end does not matter)
  function automatic logic colon_six(logic [PosW-1:0] p);
    logic r;
    case (p) inside
      5'd2, 5'd5, 5'd8, 5'd11, 5'd14: r = 1'b1;
      default:                        r = 1'b0;
    endcase
    return r;
  endfunction

  // Colon slots of the XXXX:XXXX:XXXX layout
  function automatic logic colon_three(logic [PosW-1:0] p);
    logic r;
    case (p) inside
      5'd4, 5'd9: r = 1'b1;
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/mac_address_text_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_address_text_parser: streaming MAC address text parser
// ----------------------------------------------------------------------------
// Input channel: one character per request (char_code_i, in_valid_i /
// in_ready_o). A NUL ends the string. Output channel: one result request per
// NUL (parse_ok_o, layout_o, mac_address_o, out_valid_o / out_ready_i).
// Accepted layouts: XX:XX:XX:XX:XX:XX and XXXX:XXXX:XXXX, hex of either case.
// On failure layout and address read zero.
//
// Timing: an accepted character lands in the input register and is consumed
// by the parse state at the next edge, unless it is a NUL held back (see
// Stall); a NUL's result is loaded into the output register at the edge that
// consumes the NUL, and out_valid_o rises with it.
// Throughput: one character per cycle while no NUL is held back by a stall.
// Stall: while a result is held and out_ready_i is low, a NUL in the input
// register waits; other characters keep flowing. in_ready_o follows that.
// Reset: parse state returns to the start of a string, both registers empty.
// ----------------------------------------------------------------------------
module mac_address_text_parser
  import mtp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       char_code_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             parse_ok_o,
  output logic             layout_o,
  output logic [AddrW-1:0] mac_address_o
);

  logic       in_vld_q;
  logic [7:0] char_q;
  logic       out_vld_q;
  result_t    res_q;

  logic    is_nul;
  result_t res;
  logic    out_free;
  logic    step;

  mtp_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .char_i   (char_q),
    .is_nul_o (is_nul),
    .result_o (res)
  );

  // Handshake: a NUL only moves on when the result slot is free
  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && (!is_nul || out_free);
  assign in_ready_o = !in_vld_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_code_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= step && is_nul;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && is_nul) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign parse_ok_o    = res_q.parse_ok;
  assign layout_o      = res_q.layout;
  assign mac_address_o = res_q.mac_address;

endmodule

FILE: hdl/mtp_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtp_scan: per-character parse state
// Holds position, layout match flags and the address accumulator; updates
// them on each consumed character and forms the result for a terminator.
// ----------------------------------------------------------------------------
module mtp_scan
  import mtp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,     // consume char_i this cycle
  input  logic [7:0] char_i,
  output logic       is_nul_o,
  output result_t    result_o
);

  logic [PosW-1:0]  pos_q, pos_d;
  logic             six_q, six_d;
  logic             three_q, three_d;
  logic [AddrW-1:0] acc_q, acc_d;

  hex_t hex;
  logic is_colon;
  logic ok6, ok3;

  assign hex      = hex_decode(char_i);
  assign is_colon = (char_i == CharColon);
  assign is_nul_o = (char_i == CharNul);

  // Result for a terminator, taken from the state before it
  assign ok6 = six_q && (pos_q == SixLen);
  assign ok3 = three_q && (pos_q == ThreeLen);

  always_comb begin
    result_o = '0;
    if (ok6) begin
      result_o.parse_ok    = 1'b1;
      result_o.layout      = LayoutSix;
      result_o.mac_address = acc_q;
    end else if (ok3) begin
      result_o.parse_ok    = 1'b1;
      result_o.layout      = LayoutThree;
      result_o.mac_address = acc_q;
    end
  end

  // Next state
  always_comb begin
    pos_d   = pos_q;
    six_d   = six_q;
    three_d = three_q;
    acc_d   = acc_q;
    if (step_i) begin
      if (is_nul_o) begin
        pos_d   = '0;
        six_d   = 1'b1;
        three_d = 1'b1;
        acc_d   = '0;
      end else begin
        if (pos_q >= SixLen || (colon_six(pos_q) ? !is_colon : !hex.is_hex)) begin
          six_d = 1'b0;
        end
        if (pos_q >= ThreeLen || (colon_three(pos_q) ? !is_colon : !hex.is_hex)) begin
          three_d = 1'b0;
        end
        if (hex.is_hex) begin
          acc_d = {acc_q[AddrW-5:0], hex.value};
        end
        if (pos_q != PosMax) begin
          pos_d = pos_q + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      six_q   <= 1'b1;
      three_q <= 1'b1;
      acc_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      six_q   <= six_d;
      three_q <= three_d;
      acc_q   <= acc_d;
    end
  end

endmodule

FILE: bench/mac_address_text_parser_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_address_text_parser_check: result checker for the MAC address parser
// Tracks every accepted character, predicts the result of each NUL, and
// compares each accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module mac_address_text_parser_check
  import mtp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [7:0]       char_code_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic             parse_ok_i,
  input  logic             layout_i,
  input  logic [AddrW-1:0] mac_address_i,
  output int               mismatches_o,
  output int               outstanding_o,
  output int               six_seen_o,
  output int               three_seen_o,
  output int               rejected_o
);

  // Predicted parse state
  logic [PosW-1:0]  pos_q;
  logic             six_live_q;
  logic             three_live_q;
  logic [AddrW-1:0] acc_q;

  // Results predicted but not yet seen on the output channel
  result_t due_results[$];

  // {is hex, digit value}
  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= Char0 && c <= Char9) return {1'b1, 4'(c - Char0)};
    if (c >= CharLa && c <= CharLf) return {1'b1, 4'(c - CharLa + 8'd10)};
    if (c >= CharUa && c <= CharUf) return {1'b1, 4'(c - CharUa + 8'd10)};
    return 5'b0;
  endfunction

  // Advance the prediction by one character; a NUL queues a result
  task automatic parse_char(input logic [7:0] c);
    logic [4:0] nib;
    logic       colon;
    logic       at_colon6;
    logic       at_colon3;
    result_t    r;
    if (c == CharNul) begin
      r = '0;
      if (six_live_q && pos_q == SixLen) begin
        r.parse_ok    = 1'b1;
        r.layout      = LayoutSix;
        r.mac_address = acc_q;
      end else if (three_live_q && pos_q == ThreeLen) begin
        r.parse_ok    = 1'b1;
        r.layout      = LayoutThree;
        r.mac_address = acc_q;
      end
      due_results.push_back(r);
      pos_q        = '0;
      six_live_q   = 1'b1;
      three_live_q = 1'b1;
      acc_q        = '0;
    end else begin
      nib       = nibble_of(c);
      colon     = (c == CharColon);
      at_colon6 = ((pos_q % 3) == 2);
      at_colon3 = (pos_q == 5'd4) || (pos_q == 5'd9);
      if (pos_q >= SixLen || (at_colon6 ? !colon : !nib[4])) six_live_q = 1'b0;
      if (pos_q >= ThreeLen || (at_colon3 ? !colon : !nib[4])) three_live_q = 1'b0;
      // hex digits shift in even at a colon slot
      if (nib[4]) acc_q = {acc_q[AddrW-5:0], nib[3:0]};
      if (pos_q != PosMax) pos_q = pos_q + 1'b1;
    end
  endtask

  task automatic check_field(input string what, input logic [AddrW-1:0] want_v,
                             input logic [AddrW-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
      mismatches_o++;
    end
  endtask

  // Watch both channels; results are checked before the same-edge character
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      pos_q        = '0;
      six_live_q   = 1'b1;
      three_live_q = 1'b1;
      acc_q        = '0;
      due_results.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
      six_seen_o    = 0;
      three_seen_o  = 0;
      rejected_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (!parse_ok_i) rejected_o++;
        else if (layout_i == LayoutSix) six_seen_o++;
        else three_seen_o++;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got ok=%b layout=%b addr=%h",
                   $time, parse_ok_i, layout_i, mac_address_i);
          mismatches_o++;
        end else begin
          want = due_results.pop_front();
          check_field("parse_ok", AddrW'(want.parse_ok), AddrW'(parse_ok_i));
          check_field("layout", AddrW'(want.layout), AddrW'(layout_i));
          check_field("mac_address", want.mac_address, mac_address_i);
        end
      end
      if (in_valid_i && in_ready_i) parse_char(char_code_i);
      outstanding_o = due_results.size();
    end
  end

endmodule

FILE: bench/mac_address_text_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_address_text_parser_test: testbench top for the MAC address parser
// Feeds directed strings, then random well-formed, corrupted and noise
// strings with random gaps and output stalls; the checker judges results.
// ----------------------------------------------------------------------------
module mac_address_text_parser_test;
  import mtp_pkg::*;

  localparam int CharTarget = 650;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [7:0]       char_code_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             parse_ok_o;
  logic             layout_o;
  logic [AddrW-1:0] mac_address_o;

  int mismatches;
  int outstanding;
  int six_seen;
  int three_seen;
  int rejected;

  logic       steady;
  int         chars_sent;
  int         strings_sent;
  logic [7:0] text_q[$];

  mac_address_text_parser u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .parse_ok_o   (parse_ok_o),
    .layout_o     (layout_o),
    .mac_address_o(mac_address_o)
  );

  mac_address_text_parser_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .char_code_i  (char_code_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .parse_ok_i   (parse_ok_o),
    .layout_i     (layout_o),
    .mac_address_i(mac_address_o),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding),
    .six_seen_o   (six_seen),
    .three_seen_o (three_seen),
    .rejected_o   (rejected)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #3_000_000;
    $display("Timed out with %0d results still outstanding", outstanding);
    $display("mac_address_text_parser_test: FAIL");
    $finish;
  end

  // Output backpressure
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 14);
  end

  function automatic logic [7:0] random_hex_char();
    int unsigned v;
    v = $urandom_range(15);
    if (v < 10) return Char0 + 8'(v);
    return ($urandom_range(1) ? CharUa : CharLa) + 8'(v - 10);
  endfunction

  // Characters just outside the hex ranges, the colon, plus the top byte value
  function automatic logic [7:0] edge_char();
    case ($urandom_range(8))
      0:       return Char0 - 8'd1;
      1:       return CharColon;
      2:       return Char9 + 8'd2;
      3:       return CharUa - 8'd1;
      4:       return CharUf + 8'd1;
      5:       return CharLa - 8'd1;
      6:       return CharLf + 8'd1;
      7:       return 8'hff;
      default: return random_hex_char();
    endcase
  endfunction

  // One character request, with random gaps before it
  task automatic send_char(input logic [7:0] c);
    while (!steady && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    chars_sent++;
  endtask

  // Send the built text, then its terminating NUL
  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i]);
    send_char(CharNul);
    strings_sent++;
  endtask

  task automatic send_literal(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  // Well-formed text in either layout
  task automatic build_layout(input logic three);
    int len;
    len = three ? int'(ThreeLen) : int'(SixLen);
    text_q.delete();
    for (int i = 0; i < len; i++) begin
      if (three ? (i == 4 || i == 9) : (i % 3 == 2)) text_q.push_back(CharColon);
      else text_q.push_back(random_hex_char());
    end
  endtask

  // Break a well-formed text in one way
  task automatic corrupt_text();
    int idx;
    int n;
    idx = $urandom_range(text_q.size() - 1);
    case ($urandom_range(3))
      0: text_q[idx] = 8'($urandom_range(1, 255));
      1: text_q[idx] = edge_char();
      2: begin
        n = $urandom_range(1, 3);
        repeat (n) void'(text_q.pop_back());
      end
      default: begin
        // long tails push the position into saturation
        n = $urandom_range(1, 20);
        repeat (n) text_q.push_back($urandom_range(1) ? random_hex_char() : CharColon);
      end
    endcase
  endtask

  task automatic build_noise();
    int len;
    len = $urandom_range(0, 40);
    text_q.delete();
    repeat (len) begin
      if ($urandom_range(1)) text_q.push_back(8'($urandom_range(1, 255)));
      else text_q.push_back(edge_char());
    end
  endtask

  // Stimulus and verdict
  initial begin
    int kind;
    int directed;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    char_code_i  = CharNul;
    out_ready_i  = 1'b0;
    steady       = 1'b0;
    chars_sent   = 0;
    strings_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty string, both layouts with the digit and case extremes
    send_literal("");
    send_literal("0a:9F:Af:fA:F9:00");
    send_literal("ffff:0000:9aFA");
    directed = strings_sent;

    // Random strings; one window of strings runs without any idling
    while (chars_sent < CharTarget) begin
      steady <= (strings_sent >= 20 && strings_sent < 36);
      kind = $urandom_range(99);
      if (kind < 35) build_layout(1'b0);
      else if (kind < 65) build_layout(1'b1);
      else if (kind < 85) begin
        build_layout(kind < 75);
        corrupt_text();
      end else build_noise();
      send_text();
    end
    in_valid_i <= 1'b0;

    // Drain
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d characters in %0d strings (%0d directed), gaps and stalls on both sides",
             chars_sent, strings_sent, directed);
    $display("Results seen: %0d six-group, %0d three-group, %0d rejected",
             six_seen, three_seen, rejected);
    if (mismatches == 0 && outstanding == 0) begin
      $display("mac_address_text_parser_test: PASS");
    end else begin
      $display("mac_address_text_parser_test: FAIL");
    end
    $finish;
  end

endmodule
